[src/zcss_pkg.sv]
// Shared types, codes and constants of the zero-crossing switch sequencer.
`default_nettype none

package zcss_pkg;

  // Default sizes of the switch bank and of the supply.
  localparam int SWITCH_COUNT_DEF = 18;
  localparam int PHASE_COUNT_DEF  = 3;

  // Phase slots carried through the design. Only the first three have mask registers.
  localparam int PHASE_SLOTS     = 4;
  localparam int MASKED_PHASES   = 3;
  localparam int PHASE_IDX_W     = 2;
  localparam int PHASE_SEARCH_W  = 3;
  localparam int COMP_W          = 3;
  localparam int TIMEOUT_W       = 32;
  localparam int CFG_INDEX_W     = 3;
  localparam int CFG_DATA_W      = 32;

  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 32'd1000000000;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_ZCS_ENABLE    = 3'd0,
    CFG_PHASE1_MASK   = 3'd1,
    CFG_PHASE2_MASK   = 3'd2,
    CFG_PHASE3_MASK   = 3'd3,
    CFG_TIMEOUT_TICKS = 3'd4
  } zcss_cfg_idx_t;

  typedef enum logic {
    CMD_TICK    = 1'b0,
    CMD_REQUEST = 1'b1
  } zcss_cmd_t;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_TIMEOUT = 2'd1,
    STAT_BUSY    = 2'd2
  } zcss_status_t;

  // Control state of a running sequence.
  typedef struct packed {
    logic [PHASE_IDX_W-1:0] phase;
    logic                   captured;
    logic                   timeout_seen;
    logic                   sequencing;
  } zcss_ctrl_t;

endpackage : zcss_pkg

`default_nettype wire

[src/zero_crossing_switch_sequencer.sv]
// Top level of the zero-crossing switch sequencer: registers, handshakes and configuration.
`default_nettype none

// The sequencer drives a bank of load switches from a requested on/off pattern. Each input
// transaction is either a time tick or a request carrying a new pattern, and each one yields
// exactly one result transaction with the switch drive after that step, a busy flag, a done
// flag and a status code. With zero-current switching off a request is applied at once. With
// it on, every phase whose mask register is not zero is handled in turn from phase one: the
// phase's comparator bit is captured, and the switches of that phase change only on the tick
// where the bit differs. If the timeout count of ticks passes first the phase is skipped and
// the completion reports a timeout. A request that arrives while a sequence runs is rejected
// with the busy status and the sequence carries on. An input register feeds a single pass of
// next-state logic into the result register, and the block takes one transaction per clock as
// long as the result side does not stall. The configuration port is always ready; registers
// should be written only while no sequence is running and no transaction is in flight.
module zero_crossing_switch_sequencer
  import zcss_pkg::*;
#(
  parameter int SWITCH_COUNT = SWITCH_COUNT_DEF,
  parameter int PHASE_COUNT  = PHASE_COUNT_DEF
) (
  input  var logic                    clk,
  input  var logic                    rst_n,
  // Input channel.
  input  var logic                    in_valid,
  output logic                        in_stall,
  input  var logic                    in_cmd,
  input  var logic [SWITCH_COUNT-1:0] in_desired_mask,
  input  var logic [COMP_W-1:0]       in_comp_status,
  // Result channel.
  output logic                        out_valid,
  input  var logic                    out_stall,
  output logic [SWITCH_COUNT-1:0]     out_switch_drive,
  output logic                        out_busy_res,
  output logic                        out_done_res,
  output logic [1:0]                  out_status,
  // Configuration write channel.
  input  var logic                    cfg_valid,
  output logic                        cfg_ready,
  input  var logic [CFG_INDEX_W-1:0]  cfg_index,
  input  var logic [CFG_DATA_W-1:0]   cfg_wdata
);

  // Configuration registers.
  logic                    zcs_enable_r;
  logic [SWITCH_COUNT-1:0] phase1_mask_r;
  logic [SWITCH_COUNT-1:0] phase2_mask_r;
  logic [SWITCH_COUNT-1:0] phase3_mask_r;
  logic [TIMEOUT_W-1:0]    timeout_ticks_r;

  // Input register stage.
  logic                    s1_valid_r;
  logic                    s1_cmd_r;
  logic [SWITCH_COUNT-1:0] s1_desired_r;
  logic [COMP_W-1:0]       s1_comp_r;

  // Sequencer state.
  zcss_ctrl_t              ctrl_r;
  logic [SWITCH_COUNT-1:0] switch_state_r;
  logic [SWITCH_COUNT-1:0] pending_r;
  logic [TIMEOUT_W-1:0]    wait_count_r;

  // Result register.
  logic                    out_valid_r;
  logic [SWITCH_COUNT-1:0] out_switch_r;
  logic                    out_busy_r;
  logic                    out_done_r;
  zcss_status_t            out_status_r;

  // Step logic results.
  zcss_ctrl_t              ctrl_nxt;
  logic [SWITCH_COUNT-1:0] switch_state_nxt;
  logic [SWITCH_COUNT-1:0] pending_nxt;
  logic [TIMEOUT_W-1:0]    wait_count_nxt;
  logic                    step_done;
  zcss_status_t            step_status;

  logic [PHASE_SLOTS-1:0][SWITCH_COUNT-1:0] phase_masks;
  logic s1_advance;
  logic in_accept;

  // The result register frees when it is empty or being taken this cycle.
  assign s1_advance = !out_valid_r || !out_stall;
  assign in_stall   = s1_valid_r && !s1_advance;
  assign in_accept  = in_valid && !in_stall;
  assign cfg_ready  = 1'b1;

  // Phases beyond the third have no mask register and never hold switches.
  always_comb begin
    phase_masks    = '0;
    phase_masks[0] = phase1_mask_r;
    phase_masks[1] = phase2_mask_r;
    phase_masks[2] = phase3_mask_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      zcs_enable_r    <= 1'b0;
      phase1_mask_r   <= '1;
      phase2_mask_r   <= '0;
      phase3_mask_r   <= '0;
      timeout_ticks_r <= TIMEOUT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_ZCS_ENABLE:    zcs_enable_r    <= cfg_wdata[0];
        CFG_PHASE1_MASK:   phase1_mask_r   <= cfg_wdata[SWITCH_COUNT-1:0];
        CFG_PHASE2_MASK:   phase2_mask_r   <= cfg_wdata[SWITCH_COUNT-1:0];
        CFG_PHASE3_MASK:   phase3_mask_r   <= cfg_wdata[SWITCH_COUNT-1:0];
        CFG_TIMEOUT_TICKS: timeout_ticks_r <= cfg_wdata[TIMEOUT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Input register stage: loads whenever the stage is empty or moves on.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_advance || !s1_valid_r) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_cmd_r     <= in_cmd;
      s1_desired_r <= in_desired_mask;
      s1_comp_r    <= in_comp_status;
    end
  end

  zcss_step #(
    .SWITCH_COUNT (SWITCH_COUNT),
    .PHASE_COUNT  (PHASE_COUNT)
  ) u_step (
    .cmd              (s1_cmd_r),
    .desired          (s1_desired_r),
    .comp             (s1_comp_r),
    .zcs_enable       (zcs_enable_r),
    .phase_masks      (phase_masks),
    .timeout_ticks    (timeout_ticks_r),
    .ctrl             (ctrl_r),
    .switch_state     (switch_state_r),
    .pending          (pending_r),
    .wait_count       (wait_count_r),
    .ctrl_nxt         (ctrl_nxt),
    .switch_state_nxt (switch_state_nxt),
    .pending_nxt      (pending_nxt),
    .wait_count_nxt   (wait_count_nxt),
    .done             (step_done),
    .status           (step_status)
  );

  // The sequencer state and the result register both update when the staged transaction
  // moves into the result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl_r         <= '0;
      switch_state_r <= '0;
      pending_r      <= '0;
      wait_count_r   <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      if (s1_advance) begin
        out_valid_r <= s1_valid_r;
      end
      if (s1_valid_r && s1_advance) begin
        ctrl_r         <= ctrl_nxt;
        switch_state_r <= switch_state_nxt;
        pending_r      <= pending_nxt;
        wait_count_r   <= wait_count_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid_r && s1_advance) begin
      out_switch_r <= switch_state_nxt;
      out_busy_r   <= ctrl_nxt.sequencing;
      out_done_r   <= step_done;
      out_status_r <= step_status;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_switch_drive = out_switch_r;
  assign out_busy_res     = out_busy_r;
  assign out_done_res     = out_done_r;
  assign out_status       = out_status_r;

endmodule : zero_crossing_switch_sequencer

`default_nettype wire

[src/zcss_step.sv]
// Next-state and result logic for one transaction of the sequencer.
`default_nettype none

module zcss_step
  import zcss_pkg::*;
#(
  parameter int SWITCH_COUNT = SWITCH_COUNT_DEF,
  parameter int PHASE_COUNT  = PHASE_COUNT_DEF
) (
  input  var logic                                     cmd,
  input  var logic [SWITCH_COUNT-1:0]                  desired,
  input  var logic [COMP_W-1:0]                        comp,
  input  var logic                                     zcs_enable,
  input  var logic [PHASE_SLOTS-1:0][SWITCH_COUNT-1:0] phase_masks,
  input  var logic [TIMEOUT_W-1:0]                     timeout_ticks,
  input  var zcss_ctrl_t                               ctrl,
  input  var logic [SWITCH_COUNT-1:0]                  switch_state,
  input  var logic [SWITCH_COUNT-1:0]                  pending,
  input  var logic [TIMEOUT_W-1:0]                     wait_count,
  output zcss_ctrl_t                                   ctrl_nxt,
  output logic [SWITCH_COUNT-1:0]                      switch_state_nxt,
  output logic [SWITCH_COUNT-1:0]                      pending_nxt,
  output logic [TIMEOUT_W-1:0]                         wait_count_nxt,
  output logic                                         done,
  output zcss_status_t                                 status
);

  logic [PHASE_SLOTS-1:0]    comp_ext;
  logic [PHASE_SLOTS-1:0]    nonzero;
  logic [PHASE_SEARCH_W-1:0] search_start;
  logic [PHASE_SEARCH_W-1:0] target;
  logic [TIMEOUT_W-1:0]      limit;
  logic [TIMEOUT_W:0]        count_inc;
  logic [SWITCH_COUNT-1:0]   cur_mask;
  logic                      do_enter;

  assign comp_ext = {{(PHASE_SLOTS-COMP_W){1'b0}}, comp};
  assign limit    = (timeout_ticks == '0) ? TIMEOUT_W'(1) : timeout_ticks;
  assign count_inc = {1'b0, wait_count} + (TIMEOUT_W+1)'(1);
  assign cur_mask = phase_masks[ctrl.phase];

  always_comb begin
    for (int p = 0; p < PHASE_SLOTS; p++) begin
      nonzero[p] = (phase_masks[p] != '0);
    end
  end

  // A request searches from phase one; a finished phase searches from the one after it.
  assign search_start = (cmd == CMD_REQUEST) ? '0
                      : PHASE_SEARCH_W'({1'b0, ctrl.phase}) + PHASE_SEARCH_W'(1);

  always_comb begin
    target = PHASE_SEARCH_W'(PHASE_COUNT);
    for (int p = PHASE_SLOTS - 1; p >= 0; p--) begin
      if (p < PHASE_COUNT && PHASE_SEARCH_W'(p) >= search_start && nonzero[p]) begin
        target = PHASE_SEARCH_W'(p);
      end
    end
  end

  always_comb begin
    ctrl_nxt         = ctrl;
    switch_state_nxt = switch_state;
    pending_nxt      = pending;
    wait_count_nxt   = wait_count;
    done             = 1'b0;
    status           = STAT_OK;
    do_enter         = 1'b0;

    if (cmd == CMD_REQUEST) begin
      if (ctrl.sequencing) begin
        status = STAT_BUSY;
      end else if (!zcs_enable) begin
        switch_state_nxt = desired;
        done             = 1'b1;
      end else begin
        pending_nxt           = desired;
        ctrl_nxt.timeout_seen = 1'b0;
        do_enter              = 1'b1;
      end
    end else if (ctrl.sequencing) begin
      if (comp_ext[ctrl.phase] != ctrl.captured) begin
        // The comparator changed: this is the crossing for the phase.
        switch_state_nxt = (switch_state & ~cur_mask) | (pending & cur_mask);
        do_enter         = 1'b1;
      end else begin
        wait_count_nxt = count_inc[TIMEOUT_W-1:0];
        if (count_inc >= {1'b0, limit}) begin
          ctrl_nxt.timeout_seen = 1'b1;
          do_enter              = 1'b1;
        end
      end
    end

    if (do_enter) begin
      wait_count_nxt = '0;
      if (target >= PHASE_SEARCH_W'(PHASE_COUNT)) begin
        ctrl_nxt.sequencing = 1'b0;
        ctrl_nxt.phase      = '0;
        done                = 1'b1;
        status = ctrl_nxt.timeout_seen ? STAT_TIMEOUT : STAT_OK;
      end else begin
        ctrl_nxt.sequencing = 1'b1;
        ctrl_nxt.phase      = target[PHASE_IDX_W-1:0];
        ctrl_nxt.captured   = comp_ext[target[PHASE_IDX_W-1:0]];
      end
    end
  end

endmodule : zcss_step

`default_nettype wire

[src/zcss_checker.sv]
// Port-level checks of the zero-crossing switch sequencer and their bind.
`default_nettype none

module zcss_checker
  import zcss_pkg::*;
#(
  parameter int SWITCH_COUNT = SWITCH_COUNT_DEF
) (
  input var logic                    clk,
  input var logic                    rst_n,
  input var logic                    out_valid,
  input var logic                    out_stall,
  input var logic [SWITCH_COUNT-1:0] out_switch_drive,
  input var logic                    out_busy_res,
  input var logic                    out_done_res,
  input var logic [1:0]              out_status
);

  // A completing transaction leaves the sequencer idle.
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_done_res |-> !out_busy_res)
    else $error("done reported while still busy");

  // A rejection happens only while a sequence runs and never completes anything.
  a_reject_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == STAT_BUSY |-> out_busy_res && !out_done_res)
    else $error("busy rejection outside a running sequence");

  // A timeout is reported only with the completion of a request.
  a_timeout_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == STAT_TIMEOUT |-> out_done_res)
    else $error("timeout status without completion");

  // A stalled result transaction holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_switch_drive))
    else $error("stalled result changed");

endmodule : zcss_checker

bind zero_crossing_switch_sequencer zcss_checker #(
  .SWITCH_COUNT (SWITCH_COUNT)
) u_zcss_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_switch_drive (out_switch_drive),
  .out_busy_res     (out_busy_res),
  .out_done_res     (out_done_res),
  .out_status       (out_status)
);

`default_nettype wire

[tb/sv/testbench.sv]
// Self-checking testbench for the zero-crossing switch sequencer.
module testbench;
  import zcss_pkg::*;

  localparam int SW = SWITCH_COUNT_DEF;
  localparam int PC = PHASE_COUNT_DEF;
  // Cycles after the last result before the block is treated as quiet.
  localparam int SETTLE_CYCLES = 4;
  // Cycles without any accepted transaction before the run is declared hung.
  localparam int WATCHDOG_LIMIT = 2000;
  // Length of the one long receiver hold-off.
  localparam int HOLD_OFF_CYCLES = 120;
  localparam logic [SW-1:0] ALL_SWITCHES = {SW{1'b1}};

  typedef struct packed {
    zcss_cmd_t       cmd;
    logic [SW-1:0]   desired;
    logic [COMP_W-1:0] comp;
  } switch_cmd_t;

  typedef struct packed {
    logic [SW-1:0] drive;
    logic          busy;
    logic          done;
    zcss_status_t  status;
  } switch_result_t;

  // Clock, reset and block ports. Every input starts at a known value.
  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic in_cmd = 1'b0;
  logic [SW-1:0] in_desired_mask = '0;
  logic [COMP_W-1:0] in_comp_status = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [SW-1:0] out_switch_drive;
  logic out_busy_res;
  logic out_done_res;
  logic [1:0] out_status;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  zero_crossing_switch_sequencer uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_cmd           (in_cmd),
    .in_desired_mask  (in_desired_mask),
    .in_comp_status   (in_comp_status),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_switch_drive (out_switch_drive),
    .out_busy_res     (out_busy_res),
    .out_done_res     (out_done_res),
    .out_status       (out_status),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Commands waiting to be offered, and the results the sequencer owes us, oldest first.
  switch_cmd_t    pending_cmds[$];
  switch_result_t owed_results[$];

  // Our own copy of the configuration registers, updated when a write is accepted.
  logic              reg_zcs = 1'b0;
  logic [SW-1:0]     reg_mask [MASKED_PHASES] = '{ALL_SWITCHES, '0, '0};
  logic [TIMEOUT_W-1:0] reg_timeout = TIMEOUT_RESET;

  // Our own copy of the sequencer state.
  logic [SW-1:0]        sq_drive = '0;
  logic [SW-1:0]        sq_pattern = '0;
  logic [PHASE_IDX_W-1:0] sq_phase = '0;
  logic                 sq_captured = 1'b0;
  logic [TIMEOUT_W-1:0] sq_wait = '0;
  logic                 sq_timed_out = 1'b0;
  logic                 sq_active = 1'b0;

  // Bookkeeping.
  int errors = 0;
  int cmds_queued = 0;
  int results_seen = 0;
  int requests_sent = 0;
  int busy_rejects = 0;
  int timeout_completions = 0;
  int settings_applied = 0;
  logic [COMP_W-1:0] comp_line = '0;
  logic hold_request = 1'b0;

  // The switches that belong to a phase. Slots beyond the mask registers hold none.
  function automatic logic [SW-1:0] phase_switches(input int p);
    return (p < MASKED_PHASES) ? reg_mask[p] : '0;
  endfunction

  function automatic logic comp_of(input logic [COMP_W-1:0] comp, input int p);
    return (p < COMP_W) ? comp[p] : 1'b0;
  endfunction

  // First phase at or after start that has switches; PC when there is none.
  function automatic int first_live_phase(input int start);
    for (int q = start; q < PC; q++) begin
      if (phase_switches(q) != '0) return q;
    end
    return PC;
  endfunction

  // Arms phase p, capturing its comparator bit, or closes the sequence. Returns 1 on close.
  function automatic logic open_phase(input int p, input logic [COMP_W-1:0] comp);
    if (p >= PC) begin
      sq_active = 1'b0;
      sq_phase = '0;
      sq_wait = '0;
      return 1'b1;
    end
    sq_phase = PHASE_IDX_W'(p);
    sq_captured = comp_of(comp, p);
    sq_wait = '0;
    sq_active = 1'b1;
    return 1'b0;
  endfunction

  // Advances our copy of the sequencer by one accepted command and returns the result it owes.
  function automatic switch_result_t sequence_step(input switch_cmd_t c);
    switch_result_t r;
    int p;
    logic finished;
    logic [TIMEOUT_W-1:0] limit;
    r.done = 1'b0;
    r.status = STAT_OK;
    finished = 1'b0;
    p = int'(sq_phase);
    limit = (reg_timeout == '0) ? TIMEOUT_W'(1) : reg_timeout;
    if (c.cmd == CMD_REQUEST) begin
      if (sq_active) begin
        // A request during a running sequence is turned away; the sequence carries on.
        r.status = STAT_BUSY;
      end else if (!reg_zcs) begin
        sq_drive = c.desired;
        r.done = 1'b1;
      end else begin
        sq_pattern = c.desired;
        sq_timed_out = 1'b0;
        r.done = open_phase(first_live_phase(0), c.comp);
      end
    end else if (sq_active) begin
      if (comp_of(c.comp, p) != sq_captured) begin
        // A crossing wins even on the tick where the timeout would expire.
        sq_drive = (sq_drive & ~phase_switches(p)) | (sq_pattern & phase_switches(p));
        finished = 1'b1;
      end else begin
        sq_wait = sq_wait + 1'b1;
        if (sq_wait >= limit) begin
          sq_timed_out = 1'b1;
          finished = 1'b1;
        end
      end
      if (finished && open_phase(first_live_phase(p + 1), c.comp)) begin
        r.done = 1'b1;
        r.status = sq_timed_out ? STAT_TIMEOUT : STAT_OK;
      end
    end
    r.drive = sq_drive;
    r.busy = sq_active;
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    if (errors < 20) $display("MISMATCH at result %0d: %s", results_seen, msg);
    errors++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got, input logic [31:0] want);
    if (got !== want) report_mismatch($sformatf("%s got 0x%0h, expected 0x%0h", name, got, want));
  endtask

  // Driver. Commands are offered in bursts of random length separated by random gaps. A
  // transaction completes at an edge where valid is high and stall is low; the accepted
  // command is fed to our sequencer copy right there, so the owed result is queued in order.
  int burst_left = 8;
  int gap_left = 0;

  always @(posedge clk) begin
    switch_cmd_t c;
    logic taken;
    logic offer;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      taken = in_valid && !in_stall;
      if (taken) begin
        c.cmd = zcss_cmd_t'(in_cmd);
        c.desired = in_desired_mask;
        c.comp = in_comp_status;
        owed_results.push_back(sequence_step(c));
      end
      // A stalled command stays on the port untouched.
      if (!in_valid || taken) begin
        offer = 1'b0;
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_cmds.size() > 0) begin
          c = pending_cmds.pop_front();
          in_cmd <= c.cmd;
          in_desired_mask <= c.desired;
          in_comp_status <= c.comp;
          offer = 1'b1;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 24);
            // About a quarter of the bursts run straight into the next one.
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end
        end
        in_valid <= offer;
      end
    end
  end

  // Receiver stall. Bits 7:6 of stall_cycle pick: no stall, coin flips, stall on multiples of
  // three, or rare stalls. Once in the run a long hold-off lets the sequencer back up.
  int unsigned stall_cycle = 0;
  int hold_left = 0;
  logic hold_taken = 1'b0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      stall_cycle++;
      if (hold_request && !hold_taken) begin
        hold_taken = 1'b1;
        hold_left = HOLD_OFF_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        case (stall_cycle[7:6])
          2'd0: out_stall <= 1'b0;
          2'd1: out_stall <= ($urandom_range(0, 1) == 0);
          2'd2: out_stall <= (stall_cycle % 3 == 0);
          default: out_stall <= ($urandom_range(0, 4) == 0);
        endcase
      end
    end
  end

  // Monitor. Each accepted result is checked field by field against the oldest owed one.
  always @(posedge clk) begin
    switch_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (owed_results.size() == 0) begin
        report_mismatch("result arrived with nothing owed");
      end else begin
        want = owed_results.pop_front();
        check_field("switch_drive", 32'(out_switch_drive), 32'(want.drive));
        check_field("busy_res", 32'(out_busy_res), 32'(want.busy));
        check_field("done_res", 32'(out_done_res), 32'(want.done));
        check_field("status", 32'(out_status), 32'(want.status));
        if (want.status == STAT_BUSY) busy_rejects++;
        if (want.status == STAT_TIMEOUT) timeout_completions++;
      end
      results_seen++;
    end
  end

  // Watchdog: a long run of cycles where no channel completes a transaction means a hang.
  int idle_cycles = 0;

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Watchdog expired after %0d idle cycles, %0d of %0d results seen.",
                 idle_cycles, results_seen, cmds_queued);
        $display("testbench NOT OK");
        $finish;
      end
    end
  end

  task automatic push_cmd(input zcss_cmd_t cmd, input logic [SW-1:0] desired,
                          input logic [COMP_W-1:0] comp);
    switch_cmd_t c;
    c.cmd = cmd;
    c.desired = desired;
    c.comp = comp;
    pending_cmds.push_back(c);
    cmds_queued++;
    if (cmd == CMD_REQUEST) requests_sent++;
  endtask

  // Waits until every queued command has produced its result, then lets the pipeline empty.
  task automatic drain();
    while (results_seen < cmds_queued) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Registers may only change with no sequence running, so a sequence that is still open is
  // closed by ticks that flip the comparator bit of whichever phase is armed.
  task automatic quiesce();
    drain();
    while (sq_active) begin
      push_cmd(CMD_TICK, SW'($urandom()), {COMP_W{~sq_captured}});
      drain();
    end
  endtask

  task automatic write_reg(input zcss_cfg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_ZCS_ENABLE:    reg_zcs = value[0];
      CFG_PHASE1_MASK:   reg_mask[0] = value[SW-1:0];
      CFG_PHASE2_MASK:   reg_mask[1] = value[SW-1:0];
      CFG_PHASE3_MASK:   reg_mask[2] = value[SW-1:0];
      CFG_TIMEOUT_TICKS: reg_timeout = value;
      default: ;
    endcase
    cfg_valid <= 1'b0;
  endtask

  task automatic apply_setting(input logic zcs, input logic [SW-1:0] m1, input logic [SW-1:0] m2,
                               input logic [SW-1:0] m3, input logic [TIMEOUT_W-1:0] ticks);
    quiesce();
    write_reg(CFG_ZCS_ENABLE, CFG_DATA_W'(zcs));
    write_reg(CFG_PHASE1_MASK, CFG_DATA_W'(m1));
    write_reg(CFG_PHASE2_MASK, CFG_DATA_W'(m2));
    write_reg(CFG_PHASE3_MASK, CFG_DATA_W'(m3));
    write_reg(CFG_TIMEOUT_TICKS, ticks);
    settings_applied++;
  endtask

  function automatic logic [SW-1:0] any_mask(input int zero_odds);
    if ($urandom_range(0, 99) < zero_odds) return '0;
    return SW'($urandom());
  endfunction

  // Random traffic. The comparator lines drift like real ones: mostly steady, one line
  // flipping now and then, with an occasional burst of noise. Requests carry random patterns
  // with the all-off and all-on extremes mixed in.
  task automatic queue_traffic(input int count, input int request_pct);
    logic [SW-1:0] pattern;
    for (int k = 0; k < count; k++) begin
      if ($urandom_range(0, 9) == 0) comp_line = COMP_W'($urandom());
      else if ($urandom_range(0, 2) == 0) comp_line[$urandom_range(0, COMP_W - 1)] ^= 1'b1;
      case ($urandom_range(0, 7))
        0: pattern = '0;
        1: pattern = ALL_SWITCHES;
        default: pattern = SW'($urandom());
      endcase
      if ($urandom_range(0, 99) < request_pct) push_cmd(CMD_REQUEST, pattern, comp_line);
      else push_cmd(CMD_TICK, pattern, comp_line);
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Reset configuration, immediate switching: extreme patterns and an idle tick.
    push_cmd(CMD_REQUEST, ALL_SWITCHES, 3'b000);
    push_cmd(CMD_TICK, '0, 3'b111);
    push_cmd(CMD_REQUEST, '0, 3'b101);
    push_cmd(CMD_REQUEST, 18'h2AAAA, 3'b010);
    push_cmd(CMD_REQUEST, 18'h15555, 3'b110);
    push_cmd(CMD_TICK, ALL_SWITCHES, 3'b000);

    // Three disjoint phases, short timeout. Phase one crosses, a request in the middle is
    // turned away, phase two runs out of ticks, and phase three crosses to finish with the
    // timeout status. Each phase captures its comparator bit from the step that ended the
    // previous one.
    apply_setting(1'b1, 18'h0003F, 18'h00FC0, 18'h3F000, 32'd3);
    push_cmd(CMD_REQUEST, ALL_SWITCHES, 3'b000);
    push_cmd(CMD_REQUEST, '0, 3'b000);
    push_cmd(CMD_TICK, '0, 3'b001);
    push_cmd(CMD_TICK, '0, 3'b001);
    push_cmd(CMD_TICK, '0, 3'b001);
    push_cmd(CMD_TICK, '0, 3'b001);
    push_cmd(CMD_TICK, '0, 3'b101);

    // Timeout of one tick: a crossing on the expiring tick still switches the phase.
    apply_setting(1'b1, 18'h0003F, 18'h00FC0, 18'h3F000, 32'd1);
    push_cmd(CMD_REQUEST, '0, 3'b111);
    push_cmd(CMD_TICK, '0, 3'b110);
    push_cmd(CMD_TICK, '0, 3'b110);
    push_cmd(CMD_TICK, '0, 3'b010);

    // A timeout of zero behaves as one tick.
    apply_setting(1'b1, ALL_SWITCHES, '0, '0, 32'd0);
    push_cmd(CMD_REQUEST, 18'h12345, 3'b000);
    push_cmd(CMD_TICK, '0, 3'b000);

    // No phase has switches: the request completes on its own step and changes nothing.
    apply_setting(1'b1, '0, '0, '0, 32'd5);
    push_cmd(CMD_REQUEST, ALL_SWITCHES, 3'b011);
    push_cmd(CMD_TICK, '0, 3'b101);

    // Random traffic over a spread of settings, extremes included.
    apply_setting(1'b0, any_mask(0), any_mask(0), any_mask(0), $urandom());
    queue_traffic(80, 50);
    apply_setting(1'b1, any_mask(10), any_mask(10), any_mask(10), $urandom_range(1, 6));
    queue_traffic(100, 12);
    apply_setting(1'b1, ALL_SWITCHES, ALL_SWITCHES, ALL_SWITCHES, 32'hFFFF_FFFF);
    queue_traffic(80, 10);
    apply_setting(1'b1, any_mask(35), any_mask(35), any_mask(35), 32'd0);
    queue_traffic(80, 15);

    // While this stretch is being offered, the receiver holds off for a long time so the
    // sequencer backs up and stalls its input.
    apply_setting(1'b1, any_mask(10), any_mask(10), any_mask(10), $urandom_range(2, 20));
    queue_traffic(120, 12);
    while (pending_cmds.size() > 90) @(posedge clk);
    hold_request <= 1'b1;

    apply_setting(1'b1, '0, any_mask(0), '0, 32'd1);
    queue_traffic(70, 15);
    apply_setting(1'b0, ALL_SWITCHES, '0, '0, TIMEOUT_RESET);
    queue_traffic(60, 40);

    drain();
    while (owed_results.size() > 0) begin
      void'(owed_results.pop_front());
      report_mismatch("expected result never arrived");
    end

    $display("Ran %0d commands (%0d requests) through %0d register settings.",
             cmds_queued, requests_sent, settings_applied);
    $display("Saw %0d busy rejections and %0d completions that reported a timeout.",
             busy_rejects, timeout_completions);
    if (errors == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
